>>> src/pdw_pkg.sv
package pdw_pkg;

   localparam int DEF_ENTRY_DEPTH     = 65536;
   localparam int DEF_MAX_WORD_LENGTH = 64;

   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_START   = 2'd1;
   localparam logic [1:0] KIND_ADVANCE = 2'd2;

   localparam int KIND_W       = 2;
   localparam int ADDR_W       = 16;
   localparam int WORD_W       = 32;
   localparam int INDEX_W      = 16;
   localparam int LETTER_W     = 5;
   localparam int DEPTH_W      = 6;
   localparam int CHILD_W      = 25;
   localparam int COUNT_W      = 24;
   localparam int REQ_TDATA_W  = 48;
   localparam int RSP_TDATA_W  = 56;
   localparam int RSP_PAD_W    = RSP_TDATA_W - INDEX_W - LETTER_W - DEPTH_W - 1 - COUNT_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [CHILD_W-1:0]  child;
      logic                end_node;
      logic                end_word;
      logic [LETTER_W-1:0] letter;
   } entry_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  entry_index;
      logic [LETTER_W-1:0] letter_code;
      logic [DEPTH_W-1:0]  walk_depth;
      logic                ends_word;
      logic [COUNT_W-1:0]  word_total;
      logic                walk_done;
      logic                walk_error;
   } result_type;

endpackage

>>> src/pdw_ram.sv
module pdw_ram #(
   parameter int  DEPTH = 2,
   parameter int  WIDTH = 1,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/pdw_walk_ctrl.sv
module pdw_walk_ctrl
   import pdw_pkg::*;
#(
   parameter int  ENTRY_DEPTH     = DEF_ENTRY_DEPTH,
   parameter int  MAX_WORD_LENGTH = DEF_MAX_WORD_LENGTH,
   localparam int IW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1,
   localparam int SW = (MAX_WORD_LENGTH > 1) ? $clog2(MAX_WORD_LENGTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [ADDR_W-1:0]  req_address,
   input  logic [WORD_W-1:0]  req_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output result_type         rsp_result,
   output logic               ent_wr_en,
   output logic [IW-1:0]      ent_wr_addr,
   output logic [WORD_W-1:0]  ent_wr_data,
   output logic               ent_rd_en,
   output logic [IW-1:0]      ent_rd_addr,
   input  logic [WORD_W-1:0]  ent_rd_data,
   output logic               stk_wr_en,
   output logic [SW-1:0]      stk_wr_addr,
   output logic [IW-1:0]      stk_wr_data,
   output logic               stk_rd_en,
   output logic [SW-1:0]      stk_rd_addr,
   input  logic [IW-1:0]      stk_rd_data
);

   localparam logic [32:0] EC_LIMIT  = 33'(ENTRY_DEPTH);
   localparam logic [32:0] LVL_LIMIT = 33'(MAX_WORD_LENGTH);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_EVAL    = 5'b00010,
      ST_POP_STK = 5'b00100,
      ST_POP_ENT = 5'b01000,
      ST_FINISH  = 5'b10000
   } walk_state_type;

   walk_state_type     state_ff, state_in;
   logic               active_ff, active_in;
   logic [SW-1:0]      level_ff, level_in;
   logic [IW-1:0]      cur_ff, cur_in;
   logic [COUNT_W-1:0] words_ff, words_in;
   result_type         hold_ff, hold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;

   entry_type          ent;
   logic               accept;
   logic               can_emit;
   logic [COUNT_W-1:0] count_next;

   assign ent       = entry_type'(ent_rd_data);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign count_next = (ent.end_word && (words_ff != COUNT_MAX)) ? words_ff + COUNT_W'(1)
                                                                  : words_ff;

   assign ent_wr_en   = accept && (req_kind == KIND_WRITE) && (33'(req_address) < EC_LIMIT);
   assign ent_wr_addr = IW'(req_address);
   assign ent_wr_data = req_word;
   assign ent_rd_addr = (state_ff == ST_POP_STK) ? stk_rd_data : cur_ff;

   assign stk_wr_addr = level_ff;
   assign stk_wr_data = cur_ff;
   assign stk_rd_addr = level_ff - SW'(1);

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      level_in     = level_ff;
      cur_in       = cur_ff;
      words_in     = words_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ent_rd_en    = 1'b0;
      stk_wr_en    = 1'b0;
      stk_rd_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  KIND_START: begin
                     active_in = 1'b1;
                     level_in  = '0;
                     cur_in    = '0;
                     words_in  = '0;
                  end
                  KIND_ADVANCE: begin
                     if (active_ff) begin
                        ent_rd_en = 1'b1;
                        state_in  = ST_EVAL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EVAL: begin
            hold_in.entry_index = INDEX_W'(cur_ff);
            hold_in.letter_code = ent.letter;
            hold_in.walk_depth  = DEPTH_W'(level_ff);
            hold_in.ends_word   = ent.end_word;
            hold_in.word_total  = count_next;
            hold_in.walk_done   = 1'b0;
            hold_in.walk_error  = 1'b0;
            words_in            = count_next;
            state_in            = ST_FINISH;
            if (ent.child != '0) begin
               if ((33'(level_ff) + 33'd1 >= LVL_LIMIT) || (33'(ent.child) >= EC_LIMIT)) begin
                  hold_in.walk_error = 1'b1;
                  active_in          = 1'b0;
               end else begin
                  stk_wr_en = 1'b1;
                  level_in  = level_ff + SW'(1);
                  cur_in    = IW'(ent.child);
               end
            end else if (!ent.end_node) begin
               if (33'(cur_ff) + 33'd1 >= EC_LIMIT) begin
                  hold_in.walk_error = 1'b1;
                  active_in          = 1'b0;
               end else begin
                  cur_in = cur_ff + IW'(1);
               end
            end else if (level_ff == '0) begin
               hold_in.walk_done = 1'b1;
               active_in         = 1'b0;
            end else begin
               stk_rd_en = 1'b1;
               level_in  = level_ff - SW'(1);
               state_in  = ST_POP_STK;
            end
         end
         ST_POP_STK: begin
            ent_rd_en = 1'b1;
            state_in  = ST_POP_ENT;
         end
         ST_POP_ENT: begin
            state_in = ST_FINISH;
            if (!ent.end_node) begin
               if (33'(stk_rd_data) + 33'd1 >= EC_LIMIT) begin
                  hold_in.walk_error = 1'b1;
                  active_in          = 1'b0;
               end else begin
                  cur_in = stk_rd_data + IW'(1);
               end
            end else if (level_ff == '0) begin
               hold_in.walk_done = 1'b1;
               active_in         = 1'b0;
            end else begin
               stk_rd_en = 1'b1;
               level_in  = level_ff - SW'(1);
               state_in  = ST_POP_STK;
            end
         end
         ST_FINISH: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hold_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         level_ff     <= '0;
         cur_ff       <= '0;
         words_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         level_ff     <= level_in;
         cur_ff       <= cur_in;
         words_ff     <= words_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_data_ff;

endmodule

>>> src/packed_dawg_walker.sv
// channel | direction | tdata                          | tuser      | tlast
// req_    | in        | address, entry_word            | kind       | -
// rsp_    | out       | entry_index, letter_code,      | walk_error | walk_done
//         |           | walk_depth, ends_word, word_total, pad       |
//
// Write, start, unused kinds and advances with no walk active are done in ST_IDLE.
// An advance evaluates the current entry in ST_EVAL, then ST_FINISH loads its result;
// each ancestor popped from the return stack adds a registered stack read, then an entry read.
// A held result stalls only the final step; new transactions wait until it is loaded.
// Reset is synchronous; entry and stack RAMs are not cleared.
module packed_dawg_walker
   import pdw_pkg::*;
#(
   parameter int  ENTRY_DEPTH     = DEF_ENTRY_DEPTH,
   parameter int  MAX_WORD_LENGTH = DEF_MAX_WORD_LENGTH,
   localparam int IW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1,
   localparam int SW = (MAX_WORD_LENGTH > 1) ? $clog2(MAX_WORD_LENGTH) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // address[15:0], entry_word[47:16]
   input  logic [KIND_W-1:0]      req_tuser,  // kind[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // entry_index, letter_code, walk_depth,
                                              // ends_word, word_total, zero pad
   output logic                   rsp_tlast,  // walk_done
   output logic                   rsp_tuser   // walk_error
);

   result_type         result;
   logic               ent_wr_en, ent_rd_en, stk_wr_en, stk_rd_en;
   logic [IW-1:0]      ent_wr_addr, ent_rd_addr, stk_wr_data, stk_rd_data;
   logic [WORD_W-1:0]  ent_wr_data, ent_rd_data;
   logic [SW-1:0]      stk_wr_addr, stk_rd_addr;

   pdw_walk_ctrl #(
      .ENTRY_DEPTH     (ENTRY_DEPTH),
      .MAX_WORD_LENGTH (MAX_WORD_LENGTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_tuser),
      .req_address (req_tdata[ADDR_W-1:0]),
      .req_word    (req_tdata[ADDR_W +: WORD_W]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_result  (result),
      .ent_wr_en   (ent_wr_en),
      .ent_wr_addr (ent_wr_addr),
      .ent_wr_data (ent_wr_data),
      .ent_rd_en   (ent_rd_en),
      .ent_rd_addr (ent_rd_addr),
      .ent_rd_data (ent_rd_data),
      .stk_wr_en   (stk_wr_en),
      .stk_wr_addr (stk_wr_addr),
      .stk_wr_data (stk_wr_data),
      .stk_rd_en   (stk_rd_en),
      .stk_rd_addr (stk_rd_addr),
      .stk_rd_data (stk_rd_data)
   );

   pdw_ram #(
      .DEPTH (ENTRY_DEPTH),
      .WIDTH (WORD_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   pdw_ram #(
      .DEPTH (MAX_WORD_LENGTH),
      .WIDTH (IW)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, result.word_total, result.ends_word,
                       result.walk_depth, result.letter_code, result.entry_index};
   assign rsp_tlast = result.walk_done;
   assign rsp_tuser = result.walk_error;

endmodule

>>> src/pdw_checker.sv
module pdw_checker
   import pdw_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast,
   input logic                   rsp_tuser
);

   localparam int COUNT_LSB = INDEX_W + LETTER_W + DEPTH_W + 1;
   localparam int EOW_BIT   = INDEX_W + LETTER_W + DEPTH_W;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tlast && rsp_tuser))
      else $error("walk both finished and failed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[EOW_BIT] |-> rsp_tdata[COUNT_LSB +: COUNT_W] != '0)
      else $error("word end with zero word count");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result one cycle after req transaction");

endmodule

bind packed_dawg_walker pdw_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

>>> tb/packed_dawg_walker_tb.sv
`timescale 1ns / 100ps

module packed_dawg_walker_tb;
   import pdw_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int ENTRIES   = DEF_ENTRY_DEPTH;
   localparam int MAX_LEVEL = DEF_MAX_WORD_LENGTH;
   localparam int RANDOM_ITEMS = 700;

   typedef struct packed {
      logic [15:0] base;
      logic [7:0]  count;
      logic [7:0]  level;
   } node_list_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // address[15:0], entry_word[47:16]
   logic [KIND_W-1:0]      req_tuser;   // kind[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // entry_index, letter_code, walk_depth,
                                        // ends_word, word_total, pad
   logic                   rsp_tlast;   // walk_done
   logic                   rsp_tuser;   // walk_error

   // walker state as predicted from accepted transactions
   logic [31:0]     entry_image [0:ENTRIES-1];
   bit              entry_known [0:ENTRIES-1];
   int unsigned     ancestors [0:MAX_LEVEL-1];
   int unsigned     walk_level = 0;
   int unsigned     walk_index = 0;
   logic [COUNT_W-1:0] walk_words = '0;
   bit              walk_on = 0;
   result_type      expected_visits [$];

   int mismatches     = 0;
   int items_sent     = 0;
   int walks_started  = 0;
   int steps_checked  = 0;
   int walks_finished = 0;
   int walks_failed   = 0;
   int deepest        = 0;
   int burst_left     = 0;
   int gap_odds       = 60;
   int hold_cycles    = 0;

   packed_dawg_walker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [31:0] pack_entry(input logic [4:0] letter, input bit eow,
                                              input bit eon, input logic [24:0] child);
      entry_type e;
      e.letter   = letter;
      e.end_word = eow;
      e.end_node = eon;
      e.child    = child;
      return e;
   endfunction

   task automatic predict_transaction(input logic [KIND_W-1:0] kind,
                                      input logic [15:0] addr, input logic [31:0] word);
      entry_type   e;
      entry_type   p;
      result_type  r;
      int unsigned idx;
      int unsigned parent;
      bit          done;
      bit          err;
      bit          searching;
      case (kind)
         KIND_WRITE: begin
            entry_image[addr] = word;
            entry_known[addr] = 1'b1;
         end
         KIND_START: begin
            walk_level = 0;
            walk_index = 0;
            walk_words = '0;
            walk_on    = 1'b1;
            walks_started++;
         end
         KIND_ADVANCE: begin
            if (walk_on) begin
               idx  = walk_index;
               e    = entry_image[idx];
               done = 1'b0;
               err  = 1'b0;
               r.entry_index = idx[15:0];
               r.letter_code = e.letter;
               r.walk_depth  = walk_level[5:0];
               r.ends_word   = e.end_word;
               if (e.end_word && walk_words != COUNT_MAX)
                  walk_words++;
               if (e.child != '0) begin
                  if (walk_level + 1 >= MAX_LEVEL || 32'(e.child) >= ENTRIES) begin
                     err = 1'b1;
                  end else begin
                     ancestors[walk_level] = idx;
                     walk_level++;
                     walk_index = 32'(e.child);
                  end
               end else if (!e.end_node) begin
                  if (idx + 1 >= ENTRIES)
                     err = 1'b1;
                  else
                     walk_index = idx + 1;
               end else begin
                  searching = 1'b1;
                  while (searching) begin
                     if (walk_level == 0) begin
                        done      = 1'b1;
                        searching = 1'b0;
                     end else begin
                        walk_level--;
                        parent = ancestors[walk_level];
                        p      = entry_image[parent];
                        if (!p.end_node) begin
                           searching = 1'b0;
                           if (parent + 1 >= ENTRIES)
                              err = 1'b1;
                           else
                              walk_index = parent + 1;
                        end
                     end
                  end
               end
               if (done || err)
                  walk_on = 1'b0;
               r.word_total = walk_words;
               r.walk_done  = done;
               r.walk_error = err;
               expected_visits.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [15:0] addr,
                            input logic [31:0] word);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 99) < gap_odds) ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {word, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_transaction(kind, addr, word);
      items_sent++;
   endtask

   task automatic write_entry(input logic [15:0] addr, input logic [4:0] letter,
                              input bit eow, input bit eon, input logic [24:0] child);
      send_item(KIND_WRITE, addr, pack_entry(letter, eow, eon, child));
   endtask

   task automatic start_walk();
      send_item(KIND_START, 16'($urandom), $urandom);
   endtask

   // never let the walker read an entry that holds no written value
   task automatic advance_walk();
      logic [31:0] fill;
      if (walk_on && !entry_known[walk_index]) begin
         if ($urandom_range(0, 3) != 0)
            fill = pack_entry(5'($urandom_range(1, 26)), 1'($urandom_range(0, 1)), 1'b1, '0);
         else
            fill = $urandom;
         send_item(KIND_WRITE, walk_index[15:0], fill);
      end
      send_item(KIND_ADVANCE, 16'($urandom), $urandom);
   endtask

   task automatic build_trie(input int max_depth, input int branch, input int child_pct,
                             input int max_entries);
      node_list_type pending [$];
      node_list_type nl;
      node_list_type kid;
      logic [15:0]  slots [$];
      int unsigned  next_free;
      int           placed;
      int           i;
      logic [24:0]  child;
      logic [4:0]   letter;
      bit           eow;
      nl.base  = 16'd0;
      nl.count = 8'($urandom_range(1, branch));
      nl.level = 8'd0;
      pending.push_back(nl);
      next_free = $urandom_range(8, 65400);
      placed    = 0;
      while (pending.size() > 0) begin
         nl = pending.pop_front();
         for (i = 0; i < nl.count; i++) begin
            child = '0;
            if (nl.level < max_depth && placed < max_entries &&
                $urandom_range(0, 99) < child_pct) begin
               kid.base  = 16'(next_free);
               kid.count = 8'($urandom_range(1, branch));
               kid.level = nl.level + 8'd1;
               pending.push_back(kid);
               child      = 25'(next_free);
               next_free += 32'(kid.count);
               placed    += int'(kid.count);
            end
            eow    = (child == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            letter = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 26));
            write_entry(nl.base + 16'(i), letter, eow, i == nl.count - 1, child);
            slots.push_back(nl.base + 16'(i));
         end
      end
      // damaged list: random word or a stray in-range child pointer
      if ($urandom_range(0, 4) == 0) begin
         i = $urandom_range(0, slots.size() - 1);
         if ($urandom_range(0, 1) == 0)
            send_item(KIND_WRITE, slots[i], $urandom);
         else
            write_entry(slots[i], 5'($urandom), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 25'($urandom_range(1, ENTRIES - 1)));
      end
   endtask

   task automatic run_walk(input int max_steps);
      int steps;
      start_walk();
      steps = 0;
      while (walk_on && steps < max_steps) begin
         case ($urandom_range(0, 49))
            0: send_item(KIND_UNUSED, 16'($urandom), $urandom);
            1: send_item(KIND_WRITE, 16'($urandom), $urandom);
            2: if (steps > 2) start_walk(); else advance_walk();
            default: advance_walk();
         endcase
         steps++;
      end
      if ($urandom_range(0, 7) == 0)
         advance_walk();
   endtask

   task automatic test_ignored_kinds();
      send_item(KIND_ADVANCE, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(KIND_UNUSED, 16'h0000, 32'h0000_0000);
      send_item(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_single_entry_walk();
      write_entry(16'h0000, 5'h1F, 1'b1, 1'b1, '0);
      start_walk();
      send_item(KIND_ADVANCE, 16'h0000, 32'h0000_0000);
      send_item(KIND_ADVANCE, 16'hFFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_index_range_errors();
      // child pointer beyond memory, all-zero entry as plain sibling step
      send_item(KIND_WRITE, 16'h0000, 32'h0000_0000);
      send_item(KIND_WRITE, 16'h0001, 32'hFFFF_FFFF);
      start_walk();
      repeat (2) advance_walk();
      // next sibling past the last index
      write_entry(16'h0000, 5'd1, 1'b0, 1'b1, 25'h00FFFF);
      write_entry(16'hFFFF, 5'd26, 1'b1, 1'b0, '0);
      start_walk();
      repeat (2) advance_walk();
      // pop back to a parent at the last index
      write_entry(16'hFFFF, 5'd2, 1'b0, 1'b0, 25'd1);
      write_entry(16'h0001, 5'd3, 1'b1, 1'b1, '0);
      start_walk();
      repeat (3) advance_walk();
   endtask

   task automatic test_restart();
      write_entry(16'h0000, 5'd4, 1'b0, 1'b1, 25'd2);
      write_entry(16'h0002, 5'd5, 1'b1, 1'b1, '0);
      start_walk();
      advance_walk();
      start_walk();
      repeat (2) advance_walk();
   endtask

   task automatic test_stack_limits();
      int i;
      gap_odds = 0;
      for (i = 0; i < MAX_LEVEL - 1; i++)
         write_entry(16'(i), 5'($urandom_range(1, 26)), 1'($urandom_range(0, 1)), 1'b1,
                     25'(i + 1));
      // deepest legal leaf, then unwind every level in one step
      write_entry(16'(MAX_LEVEL - 1), 5'd26, 1'b1, 1'b1, '0);
      start_walk();
      repeat (MAX_LEVEL) advance_walk();
      // one level too deep
      write_entry(16'(MAX_LEVEL - 1), 5'd26, 1'b1, 1'b1, 25'(MAX_LEVEL));
      start_walk();
      repeat (MAX_LEVEL) advance_walk();
      gap_odds = 60;
   endtask

   task automatic test_backpressure();
      gap_odds = 0;
      build_trie(6, 3, 60, 48);
      hold_cycles = 300;
      repeat (6) run_walk(60);
      gap_odds = 60;
   endtask

   task automatic test_random_walks();
      int goal;
      int pick;
      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 60;
         pick = $urandom_range(0, 9);
         if (pick < 7)
            build_trie($urandom_range(1, 5), 3, 55, 48);
         else if (pick < 9)
            build_trie($urandom_range(6, 20), 2, 70, 60);
         else
            build_trie($urandom_range(40, 64), 1, 95, 70);
         run_walk(300);
      end
   endtask

   initial begin : rsp_stall_pattern
      int stretch;
      int style;
      stretch = 0;
      style   = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            if (stretch == 0) begin
               stretch = $urandom_range(5, 60);
               style   = $urandom_range(0, 2);
            end
            stretch--;
            case (style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 99) < 60);
               default: rsp_tready <= (stretch % 5 == 0);
            endcase
         end
      end
   end

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : rsp_monitor
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.entry_index = rsp_tdata[15:0];
         got.letter_code = rsp_tdata[20:16];
         got.walk_depth  = rsp_tdata[26:21];
         got.ends_word   = rsp_tdata[27];
         got.word_total  = rsp_tdata[51:28];
         got.walk_done   = rsp_tlast;
         got.walk_error  = rsp_tuser;
         if (expected_visits.size() == 0) begin
            $display("%0t: unexpected transaction, expected none actual %0h", $time, got);
            mismatches++;
         end else begin
            want = expected_visits.pop_front();
            check_field("entry_index", 32'(want.entry_index), 32'(got.entry_index));
            check_field("letter_code", 32'(want.letter_code), 32'(got.letter_code));
            check_field("walk_depth", 32'(want.walk_depth), 32'(got.walk_depth));
            check_field("ends_word", 32'(want.ends_word), 32'(got.ends_word));
            check_field("word_total", 32'(want.word_total), 32'(got.word_total));
            check_field("walk_done", 32'(want.walk_done), 32'(got.walk_done));
            check_field("walk_error", 32'(want.walk_error), 32'(got.walk_error));
            steps_checked++;
            if (want.walk_done)
               walks_finished++;
            if (want.walk_error)
               walks_failed++;
            if (int'(want.walk_depth) > deepest)
               deepest = int'(want.walk_depth);
         end
      end
   end

   initial begin : main
      int waited;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= KIND_WRITE;
      req_tdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ignored_kinds();
      test_single_entry_walk();
      test_index_range_errors();
      test_restart();
      test_stack_limits();
      test_backpressure();
      test_random_walks();

      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_visits.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (expected_visits.size() != 0) begin
         $display("%0t: %0d expected transactions never arrived", $time,
                  expected_visits.size());
         mismatches += expected_visits.size();
      end

      $display("Covered %0d requests and %0d walks; %0d steps compared.",
               items_sent, walks_started, steps_checked);
      $display("Walks finished %0d, ended on error %0d, deepest level %0d.",
               walks_finished, walks_failed, deepest);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
